>>> rtl/indexed_deque_engine_assert.svh
`ifndef INDEXED_DEQUE_ENGINE_ASSERT_SVH
`define INDEXED_DEQUE_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IDE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define IDE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ide_pkg.sv
package ide_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 64;

  localparam int MODE_W     = 4;
  localparam int POS_W      = 4;
  localparam int VALUE_W    = 64;
  localparam int DATA_OUT_W = 64;
  localparam int COUNT_W    = 5;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 4'd0,
    MODE_PUSH_BACK  = 4'd1,
    MODE_POP_FRONT  = 4'd2,
    MODE_POP_BACK   = 4'd3,
    MODE_INSERT     = 4'd4,
    MODE_REMOVE     = 4'd5,
    MODE_READ       = 4'd6,
    MODE_OVERWRITE  = 4'd7,
    MODE_CLEAR      = 4'd8
  } mode_t;

endpackage

>>> rtl/ide_ram.sv
module ide_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/indexed_deque_engine.sv
// Push back, overwrite, clear and refused items go straight to the result; read and pop back
// first fetch the entry from the RAM. Push front and insert shift entries up, remove shifts them
// down, and pop front fetches the head and then shifts down, one move per cycle, writing back
// the last entry moved. One item is processed at a time: in_tready returns as the result enters
// the output register, so a new item can be taken while the previous result still waits there.
// rst_n (synchronous, active low) clears length, control state and out_tvalid, not the RAM.
module indexed_deque_engine
  import ide_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position[3:0], value[67:4], zero[71:68]
  input  logic [MODE_W-1:0]      in_tuser,   // mode[3:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data_out[63:0], count[68:64], zero[71:69]
  output logic                   out_tuser   // status[0]
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FETCH  = 5'b00010,
    ST_OPEN   = 5'b00100,
    ST_CLOSE  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic [LW-1:0]         ptr_r, ptr_nxt;
  logic                  wb_r, wb_nxt;
  logic [AW-1:0]         wb_addr_r, wb_addr_nxt;
  logic [DATA_WIDTH-1:0] res_data_r, res_data_nxt;
  logic                  res_fail_r, res_fail_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                  out_fail_r, out_fail_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  mode_t                 in_mode;
  logic [POS_W-1:0]      in_pos;
  logic [VALUE_W-1:0]    in_val;
  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  logic                  ins_ok;
  logic                  open_issue;
  logic                  close_issue;
  logic                  out_load;

  assign in_mode = mode_t'(in_tuser);
  assign in_pos  = in_tdata[POS_W-1:0];
  assign in_val  = in_tdata[POS_W+VALUE_W-1:POS_W];

  assign full   = (len_r == LW'(DEPTH));
  assign empty  = (len_r == '0);
  assign pos_ok = (PW'(in_pos) < PW'(len_r));
  assign ins_ok = !full && (pos_ok || ((in_pos == '0) && empty));

  assign open_issue  = (ptr_r > LW'(pos_r));
  assign close_issue = (ptr_r < len_r);

  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_RESULT) && (!out_valid_r || out_tready);

  ide_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    len_nxt      = len_r;
    ptr_nxt      = ptr_r;
    wb_nxt       = wb_r;
    wb_addr_nxt  = wb_addr_r;
    res_data_nxt = res_data_r;
    res_fail_nxt = res_fail_r;
    ram_we       = 1'b0;
    ram_waddr    = wb_addr_r;
    ram_wdata    = ram_rdata;
    ram_raddr    = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt     = in_mode;
          pos_nxt      = AW'(in_pos);
          val_nxt      = DATA_WIDTH'(in_val);
          res_data_nxt = '0;
          res_fail_nxt = 1'b0;
          wb_nxt       = 1'b0;
          state_nxt    = ST_RESULT;
          case (in_mode)
            MODE_PUSH_FRONT: begin
              if (full) begin
                res_fail_nxt = 1'b1;
              end else begin
                pos_nxt   = '0;
                ptr_nxt   = len_r;
                state_nxt = ST_OPEN;
              end
            end
            MODE_PUSH_BACK: begin
              if (full) begin
                res_fail_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(len_r);
                ram_wdata = DATA_WIDTH'(in_val);
                len_nxt   = len_r + LW'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                res_fail_nxt = 1'b1;
              end else begin
                pos_nxt   = '0;
                ram_raddr = '0;
                state_nxt = ST_FETCH;
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                res_fail_nxt = 1'b1;
              end else begin
                ram_raddr = AW'(len_r - LW'(1));
                state_nxt = ST_FETCH;
              end
            end
            MODE_INSERT: begin
              if (!ins_ok) begin
                res_fail_nxt = 1'b1;
              end else begin
                ptr_nxt   = len_r;
                state_nxt = ST_OPEN;
              end
            end
            MODE_REMOVE: begin
              if (!pos_ok) begin
                res_fail_nxt = 1'b1;
              end else begin
                ptr_nxt   = LW'(in_pos) + LW'(1);
                state_nxt = ST_CLOSE;
              end
            end
            MODE_READ: begin
              if (!pos_ok) begin
                res_fail_nxt = 1'b1;
              end else begin
                ram_raddr = AW'(in_pos);
                state_nxt = ST_FETCH;
              end
            end
            MODE_OVERWRITE: begin
              if (!pos_ok) begin
                res_fail_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(in_pos);
                ram_wdata = DATA_WIDTH'(in_val);
              end
            end
            MODE_CLEAR: begin
              len_nxt = '0;
            end
            default: begin
              res_fail_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_FETCH: begin
        res_data_nxt = ram_rdata;
        case (mode_r)
          MODE_POP_FRONT: begin
            ptr_nxt   = LW'(1);
            wb_nxt    = 1'b0;
            state_nxt = ST_CLOSE;
          end
          MODE_POP_BACK: begin
            len_nxt   = len_r - LW'(1);
            state_nxt = ST_RESULT;
          end
          default: begin
            state_nxt = ST_RESULT;
          end
        endcase
      end

      ST_OPEN: begin
        ram_raddr = AW'(ptr_r - LW'(1));
        if (wb_r) begin
          ram_we = 1'b1;
        end
        if (open_issue) begin
          ptr_nxt     = ptr_r - LW'(1);
          wb_nxt      = 1'b1;
          wb_addr_nxt = AW'(ptr_r);
        end else begin
          wb_nxt = 1'b0;
          if (!wb_r) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r;
            ram_wdata = val_r;
            len_nxt   = len_r + LW'(1);
            state_nxt = ST_RESULT;
          end
        end
      end

      ST_CLOSE: begin
        ram_raddr = AW'(ptr_r);
        if (wb_r) begin
          ram_we = 1'b1;
        end
        if (close_issue) begin
          ptr_nxt     = ptr_r + LW'(1);
          wb_nxt      = 1'b1;
          wb_addr_nxt = AW'(ptr_r - LW'(1));
        end else begin
          wb_nxt = 1'b0;
          if (!wb_r) begin
            len_nxt   = len_r - LW'(1);
            state_nxt = ST_RESULT;
          end
        end
      end

      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_fail_nxt  = out_fail_r;
    out_count_nxt = out_count_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data_r;
      out_fail_nxt  = res_fail_r;
      out_count_nxt = COUNT_W'(len_r);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      wb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      wb_r        <= wb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    ptr_r       <= ptr_nxt;
    wb_addr_r   <= wb_addr_nxt;
    res_data_r  <= res_data_nxt;
    res_fail_r  <= res_fail_nxt;
    out_data_r  <= out_data_nxt;
    out_fail_r  <= out_fail_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fail_r;
  assign out_tdata  = {(OUT_TDATA_W - DATA_OUT_W - COUNT_W)'(0), out_count_r,
                       DATA_OUT_W'(out_data_r)};

endmodule

>>> rtl/ide_checker.sv
`include "indexed_deque_engine_assert.svh"

module ide_checker
  import ide_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  logic [1:0] outstanding_r, outstanding_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    case ({in_acc, out_acc})
      2'b10:   outstanding_nxt = outstanding_r + 2'd1;
      2'b01:   outstanding_nxt = outstanding_r - 2'd1;
      default: outstanding_nxt = outstanding_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  `IDE_ASSERT_IMP(a_refused_zero_data, out_tvalid && out_tuser, out_tdata[DATA_OUT_W-1:0] == '0, "refused item carries nonzero data")
  `IDE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `IDE_ASSERT_IMP(a_no_orphan_result, out_tvalid, outstanding_r != 2'd0, "result without an accepted item")
  `IDE_ASSERT_IMP(a_two_in_flight_stall, outstanding_r == 2'd2, !in_tready, "third item taken while two are pending")

endmodule

bind indexed_deque_engine ide_checker u_ide_checker (.*);
